### rtl/lpdm_pkg.sv
// ----------------------------------------------------------------------------
// Large-page directory mapper package
// Shared widths, command codes and entry bits for the directory mapper.
// ----------------------------------------------------------------------------
package lpdm_pkg;

  localparam int unsigned DirEntriesDef = 1024;
  localparam int unsigned PageShiftDef  = 22;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned CountW    = 11;
  localparam int unsigned EntryW    = 32;
  localparam int unsigned InDataW   = 144;
  localparam int unsigned OutDataW  = 40;

  // Page size bit and present bit of a directory entry.
  localparam logic [EntryW-1:0] EntryPs = 32'h0000_0080;
  localparam logic [EntryW-1:0] EntryP  = 32'h0000_0001;

  typedef enum logic [CmdW-1:0] {
    CMD_MAP          = 3'd0,
    CMD_UNMAP        = 3'd1,
    CMD_MAP_REGION   = 3'd2,
    CMD_UNMAP_REGION = 3'd3,
    CMD_READ         = 3'd4
  } cmd_e;

endpackage

### rtl/large_page_directory_mapper_top.sv
// ----------------------------------------------------------------------------
// Large-page directory mapper
// Directory of large-page entries in one synchronous memory, filled and
// cleared in runs of consecutive entries, one memory write per cycle.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as beats on the slave stream: the command code rides in
// s_axis_tuser and the operands in s_axis_tdata. Every command answers with
// exactly one beat on the master stream, carrying the status and, for a read,
// the directory entry.
// A command other than a read is answered in the cycle after it is accepted;
// its entries are then written one per cycle, so a run keeps the slave side
// busy until its last entry (a run holds at most DIRECTORY_ENTRIES entries).
// A run is limited by the single write port of the directory memory. A read
// command is answered through the memory read register and then the answer register.
// A command that writes nothing leaves the block idle for the next command.
// After reset the block sweeps the whole memory to zero, one entry a cycle,
// and holds s_axis_tready low meanwhile.
// The answer sits in an output register; while the receiver stalls, the
// block still finishes the current run, but takes no new command until the
// waiting answer has been taken or is taken in the same cycle.
// ----------------------------------------------------------------------------
module large_page_directory_mapper_top
  import lpdm_pkg::*;
#(
  parameter int unsigned DIRECTORY_ENTRIES = DirEntriesDef,
  parameter int unsigned LARGE_PAGE_SHIFT  = PageShiftDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command beat. tdata from bit 0: phys_addr[31:0], virt_addr[31:0],
  // count[10:0], region_bytes[31:0], entry_flags[31:0], zero fill[4:0].
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser from bit 0: cmd[2:0].
  input  logic [CmdW-1:0]     s_axis_tuser,
  // Answer beat. tdata from bit 0: status[0], read_entry[31:0], zero fill[6:0].
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned IdxW  = $clog2(DIRECTORY_ENTRIES);
  localparam int unsigned CntW  = $clog2(DIRECTORY_ENTRIES + 1);
  localparam int unsigned SlotW = AddrW - LARGE_PAGE_SHIFT;
  localparam int unsigned SumW  = AddrW + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_READ
  } state_e;

  // Operand unpacking.
  logic [AddrW-1:0]  phys_addr;
  logic [AddrW-1:0]  virt_addr;
  logic [CountW-1:0] count;
  logic [AddrW-1:0]  region_bytes;
  logic [EntryW-1:0] entry_flags;
  cmd_e              cmd;

  assign phys_addr    = s_axis_tdata[31:0];
  assign virt_addr    = s_axis_tdata[63:32];
  assign count        = s_axis_tdata[74:64];
  assign region_bytes = s_axis_tdata[106:75];
  assign entry_flags  = s_axis_tdata[138:107];
  assign cmd          = cmd_e'(s_axis_tuser);

  // Directory memory, one write and one read port.
  logic [EntryW-1:0] dir_mem [DIRECTORY_ENTRIES];
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic [IdxW-1:0]   mem_raddr;
  logic [EntryW-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dir_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= dir_mem[mem_raddr];
  end

  // Control and result registers.
  state_e            state_q;
  logic [IdxW-1:0]   cursor_q;
  logic [CntW-1:0]   remain_q;
  logic [SlotW-1:0]  frame_q;
  logic [EntryW-1:0] flags_q;
  logic              map_q;
  logic              rd_ok_q;
  logic              m_valid_q;
  logic              m_status_q;
  logic [EntryW-1:0] m_entry_q;

  // Slot and offset decoding of the incoming command.
  logic [SlotW-1:0]            vslot;
  logic [SlotW-1:0]            pslot;
  logic [LARGE_PAGE_SHIFT-1:0] poff;
  logic [LARGE_PAGE_SHIFT-1:0] voff;
  logic                        vslot_ok;
  logic                        off_differ;
  logic [SumW-1:0]             region_sum;
  logic [SumW:0]               region_n;
  logic [CntW-1:0]             region_len;
  logic [CntW-1:0]             count_len;
  logic [CntW-1:0]             run_len;
  logic                        cmd_map;
  logic                        cmd_write;
  logic                        start_run;
  logic                        accept;
  logic                        run_last;
  logic                        answer_load;

  assign vslot      = virt_addr[AddrW-1:LARGE_PAGE_SHIFT];
  assign pslot      = phys_addr[AddrW-1:LARGE_PAGE_SHIFT];
  assign poff       = phys_addr[LARGE_PAGE_SHIFT-1:0];
  assign voff       = virt_addr[LARGE_PAGE_SHIFT-1:0];
  assign vslot_ok   = (AddrW'(vslot) < AddrW'(DIRECTORY_ENTRIES));
  assign off_differ = (poff != voff);

  always_comb begin
    // The containing count is formed one bit wider so the sum never wraps.
    region_sum = {1'b0, region_bytes}
                 + SumW'(((cmd == CMD_MAP_REGION) ? poff : voff));
    region_n   = (SumW + 1)'(region_sum >> LARGE_PAGE_SHIFT) + (SumW + 1)'(1);
    region_len = (region_n > (SumW + 1)'(DIRECTORY_ENTRIES))
                 ? CntW'(DIRECTORY_ENTRIES) : region_n[CntW-1:0];
    count_len  = (CountW'(count) > CountW'(DIRECTORY_ENTRIES))
                 ? CntW'(DIRECTORY_ENTRIES) : CntW'(count);

    cmd_map   = 1'b0;
    cmd_write = 1'b0;
    run_len   = count_len;
    case (cmd)
      CMD_MAP: begin
        cmd_map   = 1'b1;
        cmd_write = 1'b1;
      end
      CMD_UNMAP: begin
        cmd_write = 1'b1;
      end
      CMD_MAP_REGION: begin
        cmd_map   = 1'b1;
        cmd_write = !off_differ;
        run_len   = region_len;
      end
      CMD_UNMAP_REGION: begin
        cmd_write = 1'b1;
        run_len   = region_len;
      end
      default: begin
        cmd_write = 1'b0;
      end
    endcase
    start_run = cmd_write && vslot_ok && (run_len != '0);
  end

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The answer register loads when a command other than a read is taken or a read ends.
  assign answer_load = (accept && (cmd != CMD_READ)) || (state_q == ST_READ);

  // A run ends at its last counted entry or at the end of the directory.
  assign run_last = (remain_q == CntW'(1))
                    || (cursor_q == IdxW'(DIRECTORY_ENTRIES - 1));

  assign mem_raddr = IdxW'(vslot);
  assign mem_waddr = cursor_q;
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_RUN);
  assign mem_wdata = (map_q && (state_q == ST_RUN))
                     ? ({frame_q, {LARGE_PAGE_SHIFT{1'b0}}} | flags_q | EntryPs | EntryP)
                     : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cursor_q   <= '0;
      remain_q   <= '0;
      frame_q    <= '0;
      flags_q    <= '0;
      map_q      <= 1'b0;
      rd_ok_q    <= 1'b0;
      m_valid_q  <= 1'b0;
      m_status_q <= 1'b0;
      m_entry_q  <= '0;
    end else begin
      if (answer_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (cursor_q == IdxW'(DIRECTORY_ENTRIES - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            cursor_q <= cursor_q + IdxW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (cmd == CMD_READ) begin
              rd_ok_q <= vslot_ok;
              state_q <= ST_READ;
            end else begin
              // Commands other than reads answer at once; a run, if any, follows.
              m_status_q <= (cmd == CMD_MAP_REGION) && off_differ;
              m_entry_q  <= '0;
              if (start_run) begin
                cursor_q <= IdxW'(vslot);
                remain_q <= run_len;
                frame_q  <= pslot;
                flags_q  <= entry_flags;
                map_q    <= cmd_map;
                state_q  <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          if (run_last) begin
            state_q <= ST_IDLE;
          end else begin
            cursor_q <= cursor_q + IdxW'(1);
            remain_q <= remain_q - CntW'(1);
            frame_q  <= frame_q + SlotW'(1);
          end
        end
        ST_READ: begin
          m_status_q <= 1'b0;
          m_entry_q  <= rd_ok_q ? mem_rdata_q : '0;
          state_q    <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - EntryW - 1){1'b0}}, m_entry_q, m_status_q};

endmodule

### rtl/lpdm_checker.sv
// ----------------------------------------------------------------------------
// Large-page directory mapper port checker
// Watches the command and answer streams of the mapper top level.
// ----------------------------------------------------------------------------
module lpdm_checker
  import lpdm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [CmdW-1:0]     s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled answer beat holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("answer beat changed while stalled");

  // No new command is taken while an answer waits and is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("command taken while answer output is blocked");

  // Any command other than a read answers in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_READ) |=> m_axis_tvalid)
    else $error("write command answer missing");

  // A failed command never carries an entry, and the fill bits stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:EntryW+1] == '0)
                      && (!m_axis_tdata[0] || (m_axis_tdata[EntryW:1] == '0)))
    else $error("malformed answer beat");

endmodule

bind large_page_directory_mapper_top lpdm_checker u_lpdm_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Large-page directory mapper testbench
// Drives map, unmap, containing-region and read commands into the mapper,
// keeps its own copy of the directory to predict every answer beat, and
// checks each answer in order under varied sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import lpdm_pkg::*;

  localparam int unsigned SlotW      = AddrW - PageShiftDef;
  localparam int unsigned SettleCyc  = 40;
  localparam int unsigned MaxGap     = 24;
  localparam int unsigned ShownErrs  = 10;

  // One command as the sender sees it, before packing into a beat.
  typedef struct {
    logic [CmdW-1:0]   op;
    logic [AddrW-1:0]  phys;
    logic [AddrW-1:0]  virt;
    logic [CountW-1:0] count;
    logic [AddrW-1:0]  bytes;
    logic [EntryW-1:0] flags;
  } mapper_cmd_t;

  // One answer beat, unpacked.
  typedef struct packed {
    logic              status;
    logic [EntryW-1:0] entry;
  } answer_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow of the block's directory, updated as commands are accepted.
  logic [EntryW-1:0] directory_shadow [DirEntriesDef];
  answer_t           pending_answers [$];

  int unsigned mismatches   = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned stall_hold   = 0;

  large_page_directory_mapper_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run, including the clearing sweep.
  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver. A requested hold-off is counted down here cycle by cycle;
  // otherwise tready follows the stall rate of the current phase.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_hold > 0) begin
        m_axis_tready <= 1'b0;
        stall_hold = stall_hold - 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directory prediction
  // --------------------------------------------------------------------------

  // Fill or clear a run of consecutive entries. Entries past the end of the
  // directory are dropped, and the frame number wraps with the address width.
  function automatic void write_entry_run(input logic [AddrW-1:0] vslot,
                                          input logic [AddrW-1:0] pslot,
                                          input int unsigned run_len,
                                          input logic [EntryW-1:0] flags,
                                          input bit mapping);
    logic [AddrW-1:0] frame;
    int unsigned      idx;
    for (int unsigned i = 0; i < run_len && i < DirEntriesDef; i++) begin
      idx = vslot + i;
      if (idx >= DirEntriesDef) break;
      frame = pslot + i;
      directory_shadow[idx] = mapping ? ((frame << PageShiftDef) | flags | EntryPs | EntryP)
                                      : '0;
    end
  endfunction

  // Number of large pages touched by a region: the sum is kept one bit wider
  // than an address so that a huge size plus an offset cannot wrap.
  function automatic int unsigned region_page_count(input logic [AddrW-1:0] bytes,
                                                    input logic [AddrW-1:0] offs);
    logic [AddrW:0] span;
    span = {1'b0, bytes} + {1'b0, offs};
    return int'(span >> PageShiftDef) + 1;
  endfunction

  // Apply one accepted command to the shadow directory and return its answer.
  function automatic answer_t predict_answer(input logic [CmdW-1:0] op,
                                             input logic [InDataW-1:0] beat);
    logic [AddrW-1:0]  phys, virt, bytes, poff, voff, pslot, vslot;
    logic [CountW-1:0] cnt;
    logic [EntryW-1:0] flags;
    answer_t           ans;
    phys  = beat[31:0];
    virt  = beat[63:32];
    cnt   = beat[74:64];
    bytes = beat[106:75];
    flags = beat[138:107];
    pslot = phys >> PageShiftDef;
    vslot = virt >> PageShiftDef;
    poff  = phys & ((32'd1 << PageShiftDef) - 1);
    voff  = virt & ((32'd1 << PageShiftDef) - 1);
    ans   = '0;
    case (op)
      CMD_MAP:   write_entry_run(vslot, pslot, cnt, flags, 1'b1);
      CMD_UNMAP: write_entry_run(vslot, '0, cnt, '0, 1'b0);
      CMD_MAP_REGION: begin
        // Refused outright when the two offsets within a page disagree.
        if (poff != voff) ans.status = 1'b1;
        else write_entry_run(vslot, pslot, region_page_count(bytes, poff), flags, 1'b1);
      end
      CMD_UNMAP_REGION: write_entry_run(vslot, '0, region_page_count(bytes, voff), '0, 1'b0);
      CMD_READ: begin
        if (vslot < DirEntriesDef) ans.entry = directory_shadow[vslot];
      end
      default: ;
    endcase
    return ans;
  endfunction

  // --------------------------------------------------------------------------
  // Beat monitor and answer checker
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input answer_t want,
                                 input answer_t got, input bit have_want);
    if (mismatches < ShownErrs) begin
      if (have_want)
        $display("%0t %s: expected status %0b entry %h, got status %0b entry %h",
                 $realtime, what, want.status, want.entry, got.status, got.entry);
      else
        $display("%0t %s: got status %0b entry %h", $realtime, what, got.status, got.entry);
    end
    mismatches++;
  endtask

  // An answer can never leave in the same cycle its command is taken, so
  // predicting first and then checking keeps the queue in order.
  always @(posedge clk_i) begin : answer_monitor
    answer_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        pending_answers.push_back(predict_answer(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[0];
        got.entry  = m_axis_tdata[32:1];
        if (pending_answers.size() == 0) begin
          report_mismatch("answer beat with no command outstanding", got, got, 1'b0);
        end else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status) report_mismatch("status", want, got, 1'b1);
          if (got.entry !== want.entry) report_mismatch("read_entry", want, got, 1'b1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one command beat and return at the edge where it is taken. A gap
  // of idle cycles may go before it, following the phase's idle rate.
  task automatic issue_command(input mapper_cmd_t c);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.op;
    s_axis_tdata  <= {5'b0, c.flags, c.bytes, c.count, c.virt, c.phys};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic mapper_cmd_t make_command(input logic [CmdW-1:0] op,
                                               input logic [AddrW-1:0] phys,
                                               input logic [AddrW-1:0] virt,
                                               input logic [CountW-1:0] count,
                                               input logic [AddrW-1:0] bytes,
                                               input logic [EntryW-1:0] flags);
    mapper_cmd_t c;
    c.op = op; c.phys = phys; c.virt = virt;
    c.count = count; c.bytes = bytes; c.flags = flags;
    return c;
  endfunction

  // Stop offering and wait until every answer has come back, then give the
  // block time to finish a trailing run of writes.
  task automatic wait_answers_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Addresses cluster at the two ends of the directory so that reads hit
  // recently written entries and runs often cross the last entry.
  function automatic logic [AddrW-1:0] pick_address();
    logic [SlotW-1:0] slot;
    if ($urandom_range(4) == 0) return $urandom;
    slot = SlotW'($urandom_range(15));
    if ($urandom_range(1)) slot = slot + SlotW'(DirEntriesDef - 16);
    return {slot, PageShiftDef'($urandom_range((1 << PageShiftDef) - 1))};
  endfunction

  function automatic mapper_cmd_t random_command();
    mapper_cmd_t c;
    int unsigned pick;
    c.phys  = pick_address();
    c.virt  = pick_address();
    c.flags = $urandom_range(1) ? $urandom : ($urandom & 32'h0000_0F7E);
    pick = $urandom_range(99);
    // Mostly short runs; a few of full length or beyond.
    c.count = (pick < 85) ? CountW'($urandom_range(8))
            : (pick < 95) ? CountW'($urandom_range(2047)) : CountW'(1024);
    c.bytes = ($urandom_range(99) < 85) ? $urandom_range(32'h01FF_FFFF) : $urandom;
    pick = $urandom_range(99);
    if (pick < 25)      c.op = CMD_MAP;
    else if (pick < 35) c.op = CMD_UNMAP;
    else if (pick < 50) c.op = CMD_MAP_REGION;
    else if (pick < 58) c.op = CMD_UNMAP_REGION;
    else if (pick < 95) c.op = CMD_READ;
    else                c.op = CmdW'($urandom_range(7, CMD_READ + 1));
    // Most containing-region maps keep matching offsets so that they write.
    if (c.op == CMD_MAP_REGION && $urandom_range(4) != 0)
      c.virt[PageShiftDef-1:0] = c.phys[PageShiftDef-1:0];
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, every command and the corner cases, with no idling.
  task automatic test_directed();
    issue_command(make_command(CMD_READ, '0, '0, '0, '0, '0));
    issue_command(make_command(CMD_MAP, 32'hFFFF_FFFF, '0, 11'd1, '0, '0));
    issue_command(make_command(CMD_READ, '0, 32'h0000_0001, '0, '0, '0));
    issue_command(make_command(CMD_MAP, '0, 32'h0040_0000, 11'd0, '0, 32'hFFFF_FFFF));
    issue_command(make_command(CMD_READ, '0, 32'h0040_0000, '0, '0, '0));
    // Full directory; the frame number wraps on the last entry.
    issue_command(make_command(CMD_MAP, 32'h0040_0000, '0, 11'd1024, '0, 32'h0000_0006));
    issue_command(make_command(CMD_READ, '0, 32'hFFFF_FFFF, '0, '0, '0));
    // Flags wider than the flag bits reach into the address bits.
    issue_command(make_command(CMD_MAP, '0, 32'h0080_0000, 11'd1, '0, 32'hFFFF_FFFF));
    issue_command(make_command(CMD_READ, '0, 32'h0080_0000, '0, '0, '0));
    // A run that starts near the end loses the entries past it.
    issue_command(make_command(CMD_MAP, 32'h1234_5678, 32'hFF00_0000, 11'd2047, '0, '0));
    issue_command(make_command(CMD_UNMAP, '0, 32'hFF80_0000, 11'd2047, '0, '0));
    issue_command(make_command(CMD_READ, '0, 32'hFF40_0000, '0, '0, '0));
    issue_command(make_command(CMD_READ, '0, 32'hFF80_0000, '0, '0, '0));
    // Containing region with matching offsets spans two pages.
    issue_command(make_command(CMD_MAP_REGION, 32'h0081_2345, 32'h0101_2345, '0,
                               32'h0050_0000, 32'h0000_0002));
    issue_command(make_command(CMD_READ, '0, 32'h0141_2345, '0, '0, '0));
    // Offsets differ: refused, nothing written.
    issue_command(make_command(CMD_MAP_REGION, 32'h0081_2345, 32'h0201_2346, '0,
                               32'h0050_0000, '0));
    issue_command(make_command(CMD_READ, '0, 32'h0200_0000, '0, '0, '0));
    // Largest size plus largest offset must not wrap.
    issue_command(make_command(CMD_MAP_REGION, 32'h003F_FFFF, 32'hFA3F_FFFF, '0,
                               32'hFFFF_FFFF, '0));
    issue_command(make_command(CMD_UNMAP_REGION, '0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0));
    issue_command(make_command(CMD_UNMAP_REGION, '0, 32'h0140_0000, '0, '0, '0));
    issue_command(make_command(CMD_READ, '0, 32'hFA00_0000, '0, '0, '0));
    for (int op = CMD_READ + 1; op < (1 << CmdW); op++)
      issue_command(make_command(CmdW'(op), 32'hFFFF_FFFF, '0, 11'd1, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF));
    issue_command(make_command(CMD_READ, '0, '0, '0, '0, '0));
    wait_answers_drained();
  endtask

  task automatic test_random(input int unsigned n, input int unsigned tx_pct,
                             input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n) issue_command(random_command());
    wait_answers_drained();
  endtask

  // The receiver holds off for a long stretch while commands keep coming,
  // so the answer register fills and the block must stall its input.
  task automatic test_answer_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    stall_hold   = 400;
    repeat (24) issue_command(random_command());
    wait_answers_drained();
  endtask

  initial begin
    foreach (directory_shadow[i]) directory_shadow[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(134, 0, 0);
    test_random(134, 71, 0);
    test_random(134, 0, 71);
    test_answer_backpressure();
    test_random(134, 14, 14);
    if (pending_answers.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
